### design/hsi_pkg.sv
// ----------------------------------------------------------------------------
// hsi_pkg
// Shared types and constants of the HSI color range classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package hsi_pkg;

    localparam int MAX_SAMPLES = 16;
    localparam int IDX_W       = $clog2(MAX_SAMPLES);
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
    localparam int DVD_W       = 17;
    localparam int DVS_W       = 8;
    localparam int SCORE_W     = 4;
    localparam int HQ_W        = 15;
    localparam int HUE_SHIFT   = 22;

    localparam logic [SCORE_W-1:0] SCORE_MAX = '1;
    localparam logic [HQ_W-1:0]    HUE_RECIP = 15'd23302;
    localparam logic [8:0]         HUE_HALF  = 9'd180;
    localparam logic [8:0]         HUE_FULL  = 9'd360;
    localparam logic [DVD_W-1:0]   DEG_60    = 17'd60;
    localparam logic [DVD_W-1:0]   DEG_360   = 17'd360;

    localparam logic CFG_SAMPLE_COUNT = 1'b0;
    localparam logic CFG_MIN_MATCHES  = 1'b1;

    localparam logic FUNC_LOAD     = 1'b0;
    localparam logic FUNC_CLASSIFY = 1'b1;

    typedef struct packed {
        logic signed [7:0] hlo;
        logic signed [7:0] hhi;
        logic [7:0]        slo;
        logic [7:0]        shi;
        logic [7:0]        ilo;
        logic [7:0]        ihi;
    } range_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SAT  = 6'b000010,
        S_HDEG = 6'b000100,
        S_HQ   = 6'b001000,
        S_SCAN = 6'b010000,
        S_OUT  = 6'b100000
    } state_t;

endpackage

`default_nettype wire

### design/hsi_div.sv
// ----------------------------------------------------------------------------
// hsi_div
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// ----------------------------------------------------------------------------
`default_nettype none

module hsi_div (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [hsi_pkg::DVD_W-1:0] dividend,
    input  wire logic [hsi_pkg::DVS_W-1:0] divisor,
    output hsi_pkg::div_stat_t             stat,
    output logic [hsi_pkg::DVD_W-1:0]      quotient
);
    import hsi_pkg::*;

    localparam int STEP_W = $clog2(DVD_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DVD_W - 1);

    logic                busy_reg, busy_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [DVD_W-1:0]    dvd_reg, dvd_next;
    logic [DVS_W-1:0]    dvs_reg, dvs_next;
    logic [DVS_W-1:0]    rem_reg, rem_next;
    logic [DVS_W:0]      trial;
    logic                qbit;
    logic [DVS_W:0]      diff;

    always_comb
    begin
        trial = {rem_reg, dvd_reg[DVD_W-1]};
        qbit  = (trial >= {1'b0, dvs_reg});
        diff  = trial - {1'b0, dvs_reg};
    end

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        if (busy_reg)
        begin
            rem_next  = qbit ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            dvd_next  = {dvd_reg[DVD_W-2:0], qbit};
            step_next = step_reg + 1'b1;
            if (step_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
            end
        end
        else if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            dvd_next  = dividend;
            dvs_next  = divisor;
            rem_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = busy_reg && (step_reg == LAST_STEP);
    assign quotient  = {dvd_reg[DVD_W-2:0], qbit};

endmodule

`default_nettype wire

### design/hsi_color_range_classifier.sv
// ----------------------------------------------------------------------------
// hsi_color_range_classifier
// Converts RGB colors to HSI and scores them against a table of sample ranges.
// ----------------------------------------------------------------------------
// Items are issued with start while busy is low. A load item (func 0) writes
// one range entry in the accepting cycle and busy never rises. A classify item
// (func 1) raises busy and later produces one result, shown for one cycle with
// done high; the receiver has no way to stall it and must take it then.
// A classify item runs up to two divisions on one shared divider (saturation,
// hue in degrees), scales the hue by a reciprocal multiply in S_HQ, then
// scans the active samples one per cycle, then shows the result in S_OUT.
// Black colors skip both divisions and gray colors skip the hue division.
// The next item can be accepted in the cycle after the result at the
// earliest.
// With a last_color item the result carries the batch decision and all scores
// are cleared. Configuration writes (cfg_valid, always ready) are meant for
// idle times. Reset clears scores and sample count and sets min matches to
// one; range entries are undefined until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module hsi_color_range_classifier (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic              func,
    input  wire logic [3:0]        sample_index,
    input  wire logic signed [7:0] hue_low,
    input  wire logic signed [7:0] hue_high,
    input  wire logic [7:0]        sat_low,
    input  wire logic [7:0]        sat_high,
    input  wire logic [7:0]        bright_low,
    input  wire logic [7:0]        bright_high,
    input  wire logic [7:0]        red,
    input  wire logic [7:0]        green,
    input  wire logic [7:0]        blue,
    input  wire logic              last_color,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic              cfg_index,
    input  wire logic [4:0]        cfg_data,
    output logic                   done,
    output logic signed [7:0]      hue,
    output logic [7:0]             saturation,
    output logic [7:0]             intensity,
    output logic                   decided,
    output logic                   found,
    output logic [3:0]             match_index
);
    import hsi_pkg::*;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SAMPLES);

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     sample_count_reg;
    logic [SCORE_W-1:0]   min_matches_reg;
    range_t               range_mem [MAX_SAMPLES];
    logic [SCORE_W-1:0]   score_reg [MAX_SAMPLES];

    logic [7:0]           mx_reg, d_reg;
    logic [DVD_W-1:0]     hnum_reg;
    logic [8:0]           h_reg;
    logic signed [7:0]    hue_reg;
    logic [7:0]           sat_reg;
    logic                 last_reg;
    logic [IDX_W-1:0]     j_reg;
    logic [SCORE_W-1:0]   best_reg;
    logic [IDX_W-1:0]     bidx_reg;

    logic [7:0]           in_mx, in_mn, in_d;
    logic [DVD_W-1:0]     r17, g17, b17, d17, hnum;
    logic [CNT_W-1:0]     active;
    logic                 accept;

    logic                 div_start;
    logic [DVD_W-1:0]     div_dvd;
    logic [DVS_W-1:0]     div_dvs;
    div_stat_t            div_stat;
    logic [DVD_W-1:0]     div_q;

    logic [8:0]           h_rest;
    logic [HQ_W-1:0]      hq_num;
    logic [2*HQ_W-1:0]    hq_prod;
    logic [7:0]           hq_mag;

    range_t               entry;
    logic                 hit;
    logic [SCORE_W-1:0]   score_new;
    logic                 scan_end;

    hsi_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .stat     (div_stat),
        .quotient (div_q)
    );

    assign accept    = start && (state_reg == S_IDLE);
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign active    = (sample_count_reg > MAX_CNT) ? MAX_CNT : sample_count_reg;

    // max, min and hue numerator, the numerator in wrap-around 17-bit arithmetic
    always_comb
    begin
        in_mx = (red > green) ? red : green;
        if (blue > in_mx)
        begin
            in_mx = blue;
        end
        in_mn = (red < green) ? red : green;
        if (blue < in_mn)
        begin
            in_mn = blue;
        end
        in_d = in_mx - in_mn;
        r17  = DVD_W'(red);
        g17  = DVD_W'(green);
        b17  = DVD_W'(blue);
        d17  = DVD_W'(in_d);
        if (green > blue)
        begin
            if (red > green)
            begin
                hnum = DEG_60 * (g17 - b17);
            end
            else
            begin
                hnum = DEG_60 * ((d17 << 1) + b17 - r17);
            end
        end
        else if (red > blue)
        begin
            hnum = DEG_360 * d17 - DEG_60 * (b17 - g17);
        end
        else
        begin
            hnum = DEG_60 * ((d17 << 2) + r17 - g17);
        end
    end

    always_comb
    begin
        div_start = !div_stat.busy && ((state_reg == S_SAT) || (state_reg == S_HDEG));
        div_dvd   = ({1'b0, d_reg, 8'b0}) - DVD_W'(d_reg);
        div_dvs   = mx_reg;
        case (state_reg)
            S_HDEG:
            begin
                div_dvd = hnum_reg;
                div_dvs = d_reg;
            end
            default:
            begin
                div_dvd = ({1'b0, d_reg, 8'b0}) - DVD_W'(d_reg);
                div_dvs = mx_reg;
            end
        endcase
    end

    // hue scaling by 127/180 or 128/180 through a reciprocal multiply
    always_comb
    begin
        h_rest = HUE_FULL - h_reg;
        if (h_reg <= HUE_HALF)
        begin
            hq_num = HQ_W'({h_reg, 7'b0}) - HQ_W'(h_reg);
        end
        else
        begin
            hq_num = HQ_W'({h_rest, 7'b0});
        end
        hq_prod = hq_num * HUE_RECIP;
        hq_mag  = hq_prod[HUE_SHIFT +: 8];
    end

    // one sample checked per scan cycle
    always_comb
    begin
        entry = range_mem[j_reg];
        hit   = (hue_reg >= entry.hlo) && (hue_reg <= entry.hhi) &&
                (sat_reg >= entry.slo) && (sat_reg <= entry.shi) &&
                (mx_reg >= entry.ilo) && (mx_reg <= entry.ihi);
        score_new = score_reg[j_reg];
        if (hit && (score_reg[j_reg] != SCORE_MAX))
        begin
            score_new = score_reg[j_reg] + 1'b1;
        end
        scan_end = ({1'b0, j_reg} == (active - 1'b1));
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && (func == FUNC_CLASSIFY))
                begin
                    if (in_mx == 8'd0)
                    begin
                        state_next = (active == '0) ? S_OUT : S_SCAN;
                    end
                    else
                    begin
                        state_next = S_SAT;
                    end
                end
            end
            S_SAT:
            begin
                if (div_stat.done)
                begin
                    if (d_reg == 8'd0)
                    begin
                        state_next = (active == '0) ? S_OUT : S_SCAN;
                    end
                    else
                    begin
                        state_next = S_HDEG;
                    end
                end
            end
            S_HDEG:
            begin
                if (div_stat.done)
                begin
                    state_next = S_HQ;
                end
            end
            S_HQ:
            begin
                state_next = (active == '0) ? S_OUT : S_SCAN;
            end
            S_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            sample_count_reg <= '0;
            min_matches_reg  <= SCORE_W'(1);
            j_reg            <= '0;
            best_reg         <= '0;
            bidx_reg         <= '0;
            for (int i = 0; i < MAX_SAMPLES; i++)
            begin
                score_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_SAMPLE_COUNT: sample_count_reg <= cfg_data;
                    CFG_MIN_MATCHES:  min_matches_reg  <= cfg_data[SCORE_W-1:0];
                    default:          sample_count_reg <= sample_count_reg;
                endcase
            end
            if (accept)
            begin
                j_reg    <= '0;
                best_reg <= '0;
                bidx_reg <= '0;
            end
            if (state_reg == S_SCAN)
            begin
                score_reg[j_reg] <= score_new;
                j_reg            <= j_reg + 1'b1;
                if (last_reg && (score_new > best_reg))
                begin
                    best_reg <= score_new;
                    bidx_reg <= j_reg;
                end
            end
            if ((state_reg == S_OUT) && last_reg)
            begin
                for (int i = 0; i < MAX_SAMPLES; i++)
                begin
                    score_reg[i] <= '0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (func == FUNC_LOAD))
        begin
            range_mem[sample_index] <= '{hlo: hue_low, hhi: hue_high,
                                         slo: sat_low, shi: sat_high,
                                         ilo: bright_low, ihi: bright_high};
        end
        if (accept)
        begin
            mx_reg   <= in_mx;
            d_reg    <= in_d;
            hnum_reg <= hnum;
            last_reg <= last_color;
            hue_reg  <= '0;
            sat_reg  <= '0;
        end
        if (div_stat.done)
        begin
            case (state_reg)
                S_SAT:  sat_reg <= div_q[7:0];
                S_HDEG: h_reg   <= div_q[8:0];
                default: h_reg  <= h_reg;
            endcase
        end
        if (state_reg == S_HQ)
        begin
            hue_reg <= (h_reg <= HUE_HALF) ? hq_mag : (8'd0 - hq_mag);
        end
    end

    assign done        = (state_reg == S_OUT);
    assign hue         = hue_reg;
    assign saturation  = sat_reg;
    assign intensity   = mx_reg;
    assign decided     = last_reg;
    assign found       = last_reg && (best_reg != '0) && (best_reg >= min_matches_reg);
    assign match_index = found ? bidx_reg : '0;

    // result strobe lasts one cycle
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

    // a load never makes the block busy
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (func == FUNC_LOAD)) |=> !busy)
        else $error("load item raised busy");

    // a match is found only with a batch decision
    a_found_decided: assert property (@(posedge clk) disable iff (!rst_n)
        done && found |-> decided)
        else $error("found without decided");

    // divider runs only while a classify item is in progress
    a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.busy |-> busy)
        else $error("divider active while idle");

endmodule

`default_nettype wire

### test/tb_hsi_color_range_classifier.sv
// ----------------------------------------------------------------------------
// tb_hsi_color_range_classifier
// Self-checking bench for the HSI color range classifier.
// ----------------------------------------------------------------------------
// A queue of load and classify commands feeds a clocked driver. At each
// accepted beat the bench updates its own range table, scores and decision,
// and queues the expected HSI result. A clocked monitor compares every result
// beat field by field. Phases run with different sample counts and match
// thresholds, written while the block is idle. Stimulus is a directed part
// (primary colors, black, gray, hue wrap, full and reversed ranges) followed
// by batches of colors near loaded ranges, mixed with random noise.
// ----------------------------------------------------------------------------

module tb_hsi_color_range_classifier;

    timeunit 1ns;
    timeprecision 1ps;

    import hsi_pkg::*;

    localparam int SETTLE_CYCLES = 80;
    localparam int STALL_LIMIT   = 2000;
    localparam int PHASE_ITEMS   = 80;
    localparam int PHASES        = 8;

    typedef struct packed {
        logic              func;
        logic [3:0]        idx;
        logic signed [7:0] hlo;
        logic signed [7:0] hhi;
        logic [7:0]        slo;
        logic [7:0]        shi;
        logic [7:0]        ilo;
        logic [7:0]        ihi;
        logic [7:0]        red;
        logic [7:0]        green;
        logic [7:0]        blue;
        logic              last;
    } color_cmd_t;

    typedef struct packed {
        logic signed [7:0] hue;
        logic [7:0]        sat;
        logic [7:0]        inten;
        logic              decided;
        logic              found;
        logic [3:0]        idx;
    } hsi_result_t;

    typedef struct packed {
        logic       index;
        logic [4:0] data;
    } reg_write_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic              func = 1'b0;
    logic [3:0]        sample_index = '0;
    logic signed [7:0] hue_low = '0;
    logic signed [7:0] hue_high = '0;
    logic [7:0]        sat_low = '0;
    logic [7:0]        sat_high = '0;
    logic [7:0]        bright_low = '0;
    logic [7:0]        bright_high = '0;
    logic [7:0]        red = '0;
    logic [7:0]        green = '0;
    logic [7:0]        blue = '0;
    logic              last_color = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic              cfg_index = 1'b0;
    logic [4:0]        cfg_data = '0;
    logic              done;
    logic signed [7:0] hue;
    logic [7:0]        saturation;
    logic [7:0]        intensity;
    logic              decided;
    logic              found;
    logic [3:0]        match_index;

    color_cmd_t  cmd_queue[$];
    reg_write_t  reg_writes[$];
    hsi_result_t hsi_expected[$];
    color_cmd_t  active_cmd;

    range_t       range_tab[MAX_SAMPLES];
    logic [3:0]   score_tab[MAX_SAMPLES];
    logic [4:0]   match_count = '0;
    logic [3:0]   min_score = 4'd1;
    logic [23:0]  anchor[MAX_SAMPLES];

    logic [23:0] palette[14] = '{24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFFFF00,
                                 24'h00FFFF, 24'hFF00FF, 24'hFFFFFF, 24'h808080,
                                 24'h800000, 24'h008000, 24'hFF8000, 24'h8000FF,
                                 24'h000000, 24'hFF0001};

    logic [4:0] count_plan[PHASES] = '{5'd16, 5'd0, 5'd1, 5'd31, 5'd8, 5'd20, 5'd0, 5'd16};
    logic [4:0] min_plan[PHASES]   = '{5'd1, 5'd0, 5'd15, 5'd8, 5'd2, 5'd17, 5'd0, 5'd1};

    int  errors = 0;
    int  queued_items = 0;
    int  gap_left = 0;
    int  stall_cycles = 0;
    bit  idle_enable = 1'b1;

    hsi_color_range_classifier dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .func        (func),
        .sample_index(sample_index),
        .hue_low     (hue_low),
        .hue_high    (hue_high),
        .sat_low     (sat_low),
        .sat_high    (sat_high),
        .bright_low  (bright_low),
        .bright_high (bright_high),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .last_color  (last_color),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .done        (done),
        .hue         (hue),
        .saturation  (saturation),
        .intensity   (intensity),
        .decided     (decided),
        .found       (found),
        .match_index (match_index)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic void to_hsi(input logic [7:0] r8, input logic [7:0] g8,
                                   input logic [7:0] b8, output int hue_v,
                                   output int unsigned sat_v, output int unsigned max_v);
        int unsigned r, g, b, mn, d, deg;
        r = r8;
        g = g8;
        b = b8;
        max_v = (r > g) ? r : g;
        if (b > max_v)
            max_v = b;
        mn = (r < g) ? r : g;
        if (b < mn)
            mn = b;
        d = max_v - mn;
        sat_v = (max_v > 0) ? (255 * d) / max_v : 0;
        if (d == 0)
            hue_v = 0;
        else
        begin
            if (g > b)
                deg = (r > g) ? (60 * (g - b)) / d : (60 * (2 * d + b - r)) / d;
            else if (r > b)
                deg = (360 * d - 60 * (b - g)) / d;
            else
                deg = (60 * (4 * d + r - g)) / d;
            if (deg <= 180)
                hue_v = int'((deg * 127) / 180);
            else
                hue_v = -int'(((360 - deg) * 128) / 180);
        end
    endfunction

    task automatic score_color(input color_cmd_t c);
        int          hue_v;
        int unsigned sat_v, max_v, active, best, j;
        hsi_result_t res;
        to_hsi(c.red, c.green, c.blue, hue_v, sat_v, max_v);
        active = (match_count > MAX_SAMPLES) ? MAX_SAMPLES : match_count;
        for (j = 0; j < active; j++)
        begin
            if (hue_v >= $signed(range_tab[j].hlo) && hue_v <= $signed(range_tab[j].hhi) &&
                sat_v >= range_tab[j].slo && sat_v <= range_tab[j].shi &&
                max_v >= range_tab[j].ilo && max_v <= range_tab[j].ihi &&
                score_tab[j] < SCORE_MAX)
                score_tab[j] = score_tab[j] + 4'd1;
        end
        res.hue     = 8'(hue_v);
        res.sat     = 8'(sat_v);
        res.inten   = 8'(max_v);
        res.decided = c.last;
        res.found   = 1'b0;
        res.idx     = '0;
        if (c.last)
        begin
            best = 0;
            for (j = 0; j < active; j++)
            begin
                if (score_tab[j] > best)
                begin
                    best    = 32'(score_tab[j]);
                    res.idx = 4'(j);
                end
            end
            res.found = (best > 0) && (best >= min_score);
            if (!res.found)
                res.idx = '0;
            for (j = 0; j < MAX_SAMPLES; j++)
                score_tab[j] = '0;
        end
        hsi_expected = {hsi_expected, res};
    endtask

    function automatic void check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
        end
    endfunction

    function automatic int clamp(input int v, input int lo, input int hi);
        return (v < lo) ? lo : (v > hi) ? hi : v;
    endfunction

    function automatic color_cmd_t rand_cmd();
        color_cmd_t c;
        c.func  = 1'($urandom);
        c.idx   = 4'($urandom);
        c.hlo   = 8'($urandom);
        c.hhi   = 8'($urandom);
        c.slo   = 8'($urandom);
        c.shi   = 8'($urandom);
        c.ilo   = 8'($urandom);
        c.ihi   = 8'($urandom);
        c.red   = 8'($urandom);
        c.green = 8'($urandom);
        c.blue  = 8'($urandom);
        c.last  = 1'($urandom);
        return c;
    endfunction

    function automatic logic [23:0] near_color(input logic [23:0] rgb);
        logic [23:0] out_rgb;
        for (int k = 0; k < 3; k++)
            out_rgb[k*8 +: 8] = 8'(clamp(int'(rgb[k*8 +: 8]) + int'($urandom_range(0, 8)) - 4,
                                         0, 255));
        return out_rgb;
    endfunction

    task automatic push_cmd(input color_cmd_t c);
        cmd_queue = {cmd_queue, c};
        queued_items++;
    endtask

    task automatic push_color(input logic [23:0] rgb, input logic last);
        color_cmd_t c;
        c = rand_cmd();
        c.func  = FUNC_CLASSIFY;
        c.red   = rgb[23:16];
        c.green = rgb[15:8];
        c.blue  = rgb[7:0];
        c.last  = last;
        push_cmd(c);
    endtask

    task automatic push_range_load(input logic [3:0] idx, input logic [23:0] rgb,
                                   input int th, input int ts, input int ti);
        color_cmd_t  c;
        int          h;
        int unsigned s, i;
        to_hsi(rgb[23:16], rgb[15:8], rgb[7:0], h, s, i);
        c = rand_cmd();
        c.func = FUNC_LOAD;
        c.idx  = idx;
        c.hlo  = 8'(clamp(h - th, -128, 127));
        c.hhi  = 8'(clamp(h + th, -128, 127));
        c.slo  = 8'(clamp(int'(s) - ts, 0, 255));
        c.shi  = 8'(clamp(int'(s) + ts, 0, 255));
        c.ilo  = 8'(clamp(int'(i) - ti, 0, 255));
        c.ihi  = 8'(clamp(int'(i) + ti, 0, 255));
        anchor[idx] = rgb;
        push_cmd(c);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (cmd_queue.size() != 0 || start || reg_writes.size() != 0 || cfg_valid ||
               busy || hsi_expected.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_regs(input logic [4:0] count, input logic [4:0] minm);
        reg_write_t w;
        wait_drained();
        w.index = CFG_SAMPLE_COUNT;
        w.data  = count;
        reg_writes = {reg_writes, w};
        w.index = CFG_MIN_MATCHES;
        w.data  = minm;
        reg_writes = {reg_writes, w};
        wait_drained();
    endtask

    task automatic queue_phase(input int n);
        int          stop_at, kind, k, focus;
        logic [23:0] rgb;
        color_cmd_t  c;
        stop_at = queued_items + n;
        while (queued_items < stop_at)
        begin
            kind = $urandom_range(0, 9);
            if (kind == 0)
            begin
                c = rand_cmd();
                push_cmd(c);
            end
            else if (kind == 1)
            begin
                c = rand_cmd();
                c.func = FUNC_CLASSIFY;
                push_cmd(c);
            end
            else if (kind <= 3)
            begin
                if ($urandom_range(0, 4) == 0)
                    push_range_load(4'($urandom_range(0, 15)), 24'($urandom), 255, 255, 255);
                else
                    push_range_load(4'($urandom_range(0, 15)), 24'($urandom),
                                    $urandom_range(0, 16), $urandom_range(0, 48),
                                    $urandom_range(0, 48));
            end
            else
            begin
                k = ($urandom_range(0, 7) == 0) ? $urandom_range(16, 20) : $urandom_range(1, 8);
                focus = $urandom_range(0, 15);
                for (int n2 = 0; n2 < k; n2++)
                begin
                    if ($urandom_range(0, 4) == 0)
                        rgb = 24'($urandom);
                    else if ($urandom_range(0, 3) == 0)
                        rgb = near_color(anchor[$urandom_range(0, 15)]);
                    else
                        rgb = near_color(anchor[focus]);
                    push_color(rgb, n2 == k - 1);
                end
            end
        end
    endtask

    always @(posedge clk)
    begin : item_driver
        logic next_start;
        if (rst_n)
        begin
            next_start = start;
            if (start && !busy)
            begin
                if (active_cmd.func == FUNC_LOAD)
                begin
                    range_tab[active_cmd.idx].hlo = active_cmd.hlo;
                    range_tab[active_cmd.idx].hhi = active_cmd.hhi;
                    range_tab[active_cmd.idx].slo = active_cmd.slo;
                    range_tab[active_cmd.idx].shi = active_cmd.shi;
                    range_tab[active_cmd.idx].ilo = active_cmd.ilo;
                    range_tab[active_cmd.idx].ihi = active_cmd.ihi;
                end
                else
                    score_color(active_cmd);
                next_start = 1'b0;
            end
            if (!next_start)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (cmd_queue.size() != 0)
                begin
                    active_cmd   = cmd_queue.pop_front();
                    func         <= active_cmd.func;
                    sample_index <= active_cmd.idx;
                    hue_low      <= active_cmd.hlo;
                    hue_high     <= active_cmd.hhi;
                    sat_low      <= active_cmd.slo;
                    sat_high     <= active_cmd.shi;
                    bright_low   <= active_cmd.ilo;
                    bright_high  <= active_cmd.ihi;
                    red          <= active_cmd.red;
                    green        <= active_cmd.green;
                    blue         <= active_cmd.blue;
                    last_color   <= active_cmd.last;
                    next_start   = 1'b1;
                    if (idle_enable && $urandom_range(0, 3) == 0)
                        gap_left = $urandom_range(1, 5);
                end
            end
            start <= next_start;
        end
    end

    always @(posedge clk)
    begin : reg_driver
        reg_write_t w;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_SAMPLE_COUNT)
                    match_count = cfg_data;
                else
                    min_score = cfg_data[3:0];
            end
            if (!cfg_valid || cfg_ready)
            begin
                if (reg_writes.size() != 0)
                begin
                    w = reg_writes.pop_front();
                    cfg_index <= w.index;
                    cfg_data  <= w.data;
                    cfg_valid <= 1'b1;
                end
                else
                    cfg_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : result_monitor
        hsi_result_t exp_r;
        if (rst_n && done)
        begin
            if (hsi_expected.size() == 0)
            begin
                $error("result beat with no expected result");
                errors++;
            end
            else
            begin
                exp_r = hsi_expected.pop_front();
                check_field("hue", exp_r.hue, hue);
                check_field("saturation", exp_r.sat, saturation);
                check_field("intensity", exp_r.inten, intensity);
                check_field("decided", exp_r.decided, decided);
                check_field("found", exp_r.found, found);
                check_field("match_index", exp_r.idx, match_index);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || (cfg_valid && cfg_ready) || done)
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        color_cmd_t c;
        for (int j = 0; j < MAX_SAMPLES; j++)
        begin
            score_tab[j] = '0;
            anchor[j]    = 24'($urandom);
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // no active samples yet, black color closes a batch
        push_color(24'h000000, 1'b1);
        c = rand_cmd();
        c.func = FUNC_LOAD;
        c.idx  = 4'd0;
        c.hlo  = -8'sd128;
        c.hhi  = 8'sd127;
        c.slo  = 8'd0;
        c.shi  = 8'd255;
        c.ilo  = 8'd0;
        c.ihi  = 8'd255;
        push_cmd(c);
        // reversed bounds never match
        c = rand_cmd();
        c.func = FUNC_LOAD;
        c.idx  = 4'd1;
        c.hlo  = 8'sd20;
        c.hhi  = -8'sd20;
        c.slo  = 8'd200;
        c.shi  = 8'd10;
        c.ilo  = 8'd255;
        c.ihi  = 8'd0;
        push_cmd(c);
        for (int j = 2; j < MAX_SAMPLES; j++)
            push_range_load(4'(j), palette[j-2], 4, 16, 16);
        set_regs(5'd16, 5'd1);

        push_color(24'hFFFFFF, 1'b0);
        push_color(24'h808080, 1'b0);
        push_color(24'hFF0000, 1'b0);
        push_color(24'h00FF00, 1'b0);
        push_color(24'h0000FF, 1'b0);
        push_color(24'hFF00FF, 1'b0);
        push_color(24'hFF0001, 1'b0);
        push_color(24'hFFFFFE, 1'b0);
        push_color(24'h010000, 1'b1);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph == 6)
                set_regs(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
            else
                set_regs(count_plan[ph], min_plan[ph]);
            idle_enable = (ph < PHASES - 1);
            queue_phase(PHASE_ITEMS);
        end
        wait_drained();

        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
